// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/atcmp_pkg.sv =====
// types and constants of the tip carving block
package atcmp_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CENTER,
        S_DIST,
        S_CARVE,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_TIP_WRITE = 2'd0,
        OP_CARVE     = 2'd1,
        OP_READ      = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_SURF_W = 2'd0,
        CFG_SURF_H = 2'd1,
        CFG_TIP_W  = 2'd2,
        CFG_TIP_H  = 2'd3
    } t_cfg_idx;

    localparam int SURF_REG_W = 9;
    localparam int TIP_REG_W  = 6;
    localparam int COORD_W    = 8;
    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int DIST_W     = SAMPLE_W + 1;
    localparam int CARVE_W    = SAMPLE_W + 2;

    localparam logic signed [VALUE_W-1:0] SENTINEL = 32'sd2147000000;

endpackage

// ===== sv/afm_tip_carve_min_plus.sv =====
// tip carving block: min-plus grayscale dilation of a boundary store by a tip image
// Items enter on the s_axis side one at a time and each gives one result transfer on m_axis.
// A carve in range runs through these steps: fetch the tip centre, form the distance, take
// each tip entry through a pipelined read-modify-write on the boundary RAM, drain the last
// write and register the result. Tip writes, reads and out-of-range carves go straight to
// registering the result. A clear sweeps the whole boundary RAM one entry per cycle; the
// same sweep runs after reset before the first item is taken. Once the result is registered
// the next item can be taken; registering waits while an earlier result still waits on
// m_axis_tready. Configuration writes take effect at once and belong between items, with
// nothing in flight.
module afm_tip_carve_min_plus #(
    parameter int MAX_SURFACE_DIM = 256,
    parameter int MAX_TIP_DIM     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // col[7:0], row[15:8], sample[31:16]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_value[31:0], untouched[32], zero fill[39:33]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int SA = (MAX_SURFACE_DIM > 1) ? $clog2(MAX_SURFACE_DIM) : 1;
    localparam int TA = (MAX_TIP_DIM > 1) ? $clog2(MAX_TIP_DIM) : 1;
    localparam int MW = (SA > atcmp_pkg::COORD_W) ? SA : atcmp_pkg::COORD_W;
    localparam int CW = ((MW > TA) ? MW : TA) + 2;
    localparam int BND_DEPTH = 2 ** (2 * SA);
    localparam int TIP_DEPTH = 2 ** (2 * TA);
    localparam int VW = atcmp_pkg::VALUE_W;
    localparam int SMW = atcmp_pkg::SAMPLE_W;

    typedef logic signed [CW-1:0] t_crd;

    // configuration
    logic [atcmp_pkg::SURF_REG_W-1:0] r_surf_w, r_surf_h;
    logic [atcmp_pkg::TIP_REG_W-1:0]  r_tip_w, r_tip_h;

    // control and payload registers
    atcmp_pkg::t_state r_state, n_state;
    atcmp_pkg::t_op    r_op;
    logic [2*SA-1:0]   r_clr_cnt;
    logic              r_emit;
    logic [TA-1:0]     r_k, r_l;
    logic              r_p1_vld;
    logic [2*SA-1:0]   r_p1_addr;
    logic signed [atcmp_pkg::DIST_W-1:0] r_dist;
    logic [7:0]        r_col, r_row;
    logic signed [SMW-1:0] r_smp;
    logic              r_rd_ok;
    logic              r_out_valid;
    logic signed [VW-1:0] r_out_value;
    logic              r_out_untouched;

    // memories
    logic signed [VW-1:0]  r_bnd_mem [BND_DEPTH];
    logic signed [SMW-1:0] r_tip_mem [TIP_DEPTH];
    logic signed [VW-1:0]  r_bnd_q;
    logic signed [SMW-1:0] r_tip_q;

    // combinational
    t_crd sw, sh, tw, th, cx, cy;
    t_crd sw_raw, sh_raw, tw_raw, th_raw;
    t_crd in_col_c, in_row_c, col_c, row_c, k_c, l_c, x, y;
    atcmp_pkg::t_op in_op;
    logic acc, in_surf_ok, in_tip_ok, tgt_ok, k_last, l_last, out_free;
    logic bnd_re, bnd_we, tip_re, tip_we, upd;
    logic [2*SA-1:0] bnd_raddr, bnd_waddr;
    logic signed [VW-1:0] bnd_wdata;
    logic [2*TA-1:0] tip_raddr, tip_waddr;
    logic signed [atcmp_pkg::CARVE_W-1:0] carved;
    logic signed [VW-1:0] carved_ext;
    logic signed [VW-1:0] res_value;
    logic res_untouched;

    // effective dimensions, saturated into their legal range
    always_comb begin
        sw_raw = $signed({{(CW-atcmp_pkg::SURF_REG_W){1'b0}}, r_surf_w});
        sh_raw = $signed({{(CW-atcmp_pkg::SURF_REG_W){1'b0}}, r_surf_h});
        tw_raw = $signed({{(CW-atcmp_pkg::TIP_REG_W){1'b0}}, r_tip_w});
        th_raw = $signed({{(CW-atcmp_pkg::TIP_REG_W){1'b0}}, r_tip_h});
        sw = (sw_raw == '0) ? t_crd'(1) :
             (sw_raw > t_crd'(MAX_SURFACE_DIM)) ? t_crd'(MAX_SURFACE_DIM) : sw_raw;
        sh = (sh_raw == '0) ? t_crd'(1) :
             (sh_raw > t_crd'(MAX_SURFACE_DIM)) ? t_crd'(MAX_SURFACE_DIM) : sh_raw;
        tw = (tw_raw == '0) ? t_crd'(1) :
             (tw_raw > t_crd'(MAX_TIP_DIM)) ? t_crd'(MAX_TIP_DIM) : tw_raw;
        th = (th_raw == '0) ? t_crd'(1) :
             (th_raw > t_crd'(MAX_TIP_DIM)) ? t_crd'(MAX_TIP_DIM) : th_raw;
        // parity of the tip width picks the centre rule for both axes
        cx = tw[0] ? (tw >>> 1) : (tw >>> 1) - t_crd'(1);
        cy = tw[0] ? (th >>> 1) : (th >>> 1) - t_crd'(1);
    end

    // input side and carve address generation
    always_comb begin
        in_op    = atcmp_pkg::t_op'(s_axis_tuser);
        in_col_c = $signed({{(CW-8){1'b0}}, s_axis_tdata[7:0]});
        in_row_c = $signed({{(CW-8){1'b0}}, s_axis_tdata[15:8]});
        acc      = s_axis_tvalid && s_axis_tready;
        in_surf_ok = (in_col_c < sw) && (in_row_c < sh);
        in_tip_ok  = (in_col_c < tw) && (in_row_c < th);

        col_c = $signed({{(CW-8){1'b0}}, r_col});
        row_c = $signed({{(CW-8){1'b0}}, r_row});
        k_c   = $signed({{(CW-TA){1'b0}}, r_k});
        l_c   = $signed({{(CW-TA){1'b0}}, r_l});
        x     = col_c + k_c - cx;
        y     = row_c + l_c - cy;
        tgt_ok = (x >= t_crd'(0)) && (x < sw) && (y >= t_crd'(0)) && (y < sh);
        k_last = (k_c == tw - t_crd'(1));
        l_last = (l_c == th - t_crd'(1));
        out_free = !r_out_valid || m_axis_tready;

        carved = {r_dist[atcmp_pkg::DIST_W-1], r_dist} - {{2{r_tip_q[SMW-1]}}, r_tip_q};
        carved_ext = {{(VW-atcmp_pkg::CARVE_W){carved[atcmp_pkg::CARVE_W-1]}}, carved};
        upd = r_p1_vld && (r_tip_q != '0) && (carved_ext < r_bnd_q);

        res_value = (r_op == atcmp_pkg::OP_READ && r_rd_ok) ? r_bnd_q : '0;
        res_untouched = (r_op == atcmp_pkg::OP_READ) && r_rd_ok &&
                        (r_bnd_q == atcmp_pkg::SENTINEL);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            atcmp_pkg::S_CLEAR: begin
                if (r_clr_cnt == '1) begin
                    n_state = r_emit ? atcmp_pkg::S_DONE : atcmp_pkg::S_IDLE;
                end
            end
            atcmp_pkg::S_IDLE: begin
                if (acc) begin
                    case (in_op)
                        atcmp_pkg::OP_CARVE: begin
                            n_state = in_surf_ok ? atcmp_pkg::S_CENTER : atcmp_pkg::S_DONE;
                        end
                        atcmp_pkg::OP_CLEAR: n_state = atcmp_pkg::S_CLEAR;
                        default:             n_state = atcmp_pkg::S_DONE;
                    endcase
                end
            end
            atcmp_pkg::S_CENTER: n_state = atcmp_pkg::S_DIST;
            atcmp_pkg::S_DIST:   n_state = atcmp_pkg::S_CARVE;
            atcmp_pkg::S_CARVE: begin
                if (k_last && l_last) begin
                    n_state = atcmp_pkg::S_DRAIN;
                end
            end
            atcmp_pkg::S_DRAIN: n_state = atcmp_pkg::S_DONE;
            atcmp_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = atcmp_pkg::S_IDLE;
                end
            end
            default: n_state = atcmp_pkg::S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        s_axis_tready = (r_state == atcmp_pkg::S_IDLE);
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = {7'd0, r_out_untouched, r_out_value};

        bnd_re    = (acc && in_op == atcmp_pkg::OP_READ) || (r_state == atcmp_pkg::S_CARVE);
        bnd_raddr = (r_state == atcmp_pkg::S_IDLE) ? {in_row_c[SA-1:0], in_col_c[SA-1:0]}
                                                   : {y[SA-1:0], x[SA-1:0]};
        if (r_state == atcmp_pkg::S_CLEAR) begin
            bnd_we    = 1'b1;
            bnd_waddr = r_clr_cnt;
            bnd_wdata = atcmp_pkg::SENTINEL;
        end else begin
            bnd_we    = (r_state == atcmp_pkg::S_CARVE || r_state == atcmp_pkg::S_DRAIN) && upd;
            bnd_waddr = r_p1_addr;
            bnd_wdata = carved_ext;
        end

        tip_re    = (r_state == atcmp_pkg::S_CENTER) || (r_state == atcmp_pkg::S_CARVE);
        tip_raddr = (r_state == atcmp_pkg::S_CENTER) ? {cy[TA-1:0], cx[TA-1:0]} : {r_l, r_k};
        tip_we    = acc && in_op == atcmp_pkg::OP_TIP_WRITE && in_tip_ok;
        tip_waddr = {in_row_c[TA-1:0], in_col_c[TA-1:0]};
    end

    // boundary and tip memories
    always_ff @(posedge i_clk) begin
        if (bnd_we) begin
            r_bnd_mem[bnd_waddr] <= bnd_wdata;
        end
        if (bnd_re) begin
            r_bnd_q <= r_bnd_mem[bnd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tip_we) begin
            r_tip_mem[tip_waddr] <= $signed(s_axis_tdata[31:16]);
        end
        if (tip_re) begin
            r_tip_q <= r_tip_mem[tip_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w <= 9'd256;
            r_surf_h <= 9'd256;
            r_tip_w  <= 6'd32;
            r_tip_h  <= 6'd32;
        end else if (i_cfg_we) begin
            case (atcmp_pkg::t_cfg_idx'(i_cfg_index))
                atcmp_pkg::CFG_SURF_W: r_surf_w <= i_cfg_data;
                atcmp_pkg::CFG_SURF_H: r_surf_h <= i_cfg_data;
                atcmp_pkg::CFG_TIP_W:  r_tip_w  <= i_cfg_data[atcmp_pkg::TIP_REG_W-1:0];
                atcmp_pkg::CFG_TIP_H:  r_tip_h  <= i_cfg_data[atcmp_pkg::TIP_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atcmp_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_emit      <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_l         <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == atcmp_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end

            if (acc) begin
                r_emit <= 1'b1;
            end

            case (r_state)
                atcmp_pkg::S_DIST: begin
                    r_k      <= '0;
                    r_l      <= '0;
                    r_p1_vld <= 1'b0;
                end
                atcmp_pkg::S_CARVE: begin
                    r_p1_vld <= tgt_ok;
                    if (l_last) begin
                        r_l <= '0;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_l <= r_l + 1'b1;
                    end
                end
                default: r_p1_vld <= 1'b0;
            endcase

            if (r_state == atcmp_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op    <= in_op;
            r_col   <= s_axis_tdata[7:0];
            r_row   <= s_axis_tdata[15:8];
            r_smp   <= $signed(s_axis_tdata[31:16]);
            r_rd_ok <= in_surf_ok;
        end
        if (r_state == atcmp_pkg::S_CARVE) begin
            r_p1_addr <= {y[SA-1:0], x[SA-1:0]};
        end
        // centre outside the tip counts as height zero
        if (r_state == atcmp_pkg::S_DIST) begin
            r_dist <= (cy < t_crd'(0)) ? {r_smp[SMW-1], r_smp}
                                       : {r_smp[SMW-1], r_smp} + {r_tip_q[SMW-1], r_tip_q};
        end
        if (r_state == atcmp_pkg::S_DONE && out_free) begin
            r_out_value     <= res_value;
            r_out_untouched <= res_untouched;
        end
    end

endmodule

// ===== sv/atcmp_chk.sv =====
// port checker for the tip carving block, bound to the top level
`include "assert_macros.svh"

module atcmp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one item in flight: ready drops after every input transfer
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // untouched flag only rides on a sentinel value
    `ASSERT_IMPLIES(a_untouched_sentinel, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:0] == atcmp_pkg::SENTINEL)

    // fill bits stay zero
    `ASSERT_IMPLIES(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)

endmodule

bind afm_tip_carve_min_plus atcmp_chk u_atcmp_chk (.*);

// ===== dv/tb.sv =====
// testbench for the tip carving block: streams tip, carve, read and clear items against a predictor
`timescale 1ns / 100ps

module tb;

    localparam int SURF_DIM   = 256;
    localparam int TIP_DIM    = 32;
    localparam int CYCLE_CAP  = 3000000;
    localparam int PHASES     = 10;
    localparam int PHASE_ITEMS = 40;

    typedef struct {
        logic signed [atcmp_pkg::VALUE_W-1:0] value;
        logic                                 untouched;
    } t_read_result;

    // predictor of the boundary and tip stores plus the queue of results still owed
    class carve_scoreboard;
        logic [8:0]   reg_file [4];
        int           boundary [SURF_DIM*SURF_DIM];
        shortint      tip_map [TIP_DIM][TIP_DIM];
        t_read_result owed_q [$];
        int errors;
        int n_tip, n_carve, n_read, n_clear, n_cfg;

        function new();
            reg_file[atcmp_pkg::CFG_SURF_W] = 9'd256;
            reg_file[atcmp_pkg::CFG_SURF_H] = 9'd256;
            reg_file[atcmp_pkg::CFG_TIP_W]  = 9'd32;
            reg_file[atcmp_pkg::CFG_TIP_H]  = 9'd32;
            foreach (tip_map[r, c]) tip_map[r][c] = 0;
            wipe_boundary();
        endfunction

        function void wipe_boundary();
            foreach (boundary[i]) boundary[i] = atcmp_pkg::SENTINEL;
        endfunction

        function void set_reg(atcmp_pkg::t_cfg_idx idx, logic [8:0] val);
            if (idx == atcmp_pkg::CFG_TIP_W || idx == atcmp_pkg::CFG_TIP_H)
                reg_file[idx] = {3'b0, val[5:0]};
            else reg_file[idx] = val;
            n_cfg++;
        endfunction

        // saturate a size register into 1..maxv
        function int fit(logic [8:0] v, int maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return int'(v);
        endfunction

        function void sizes(output int sw, output int sh, output int tw, output int th);
            sw = fit(reg_file[atcmp_pkg::CFG_SURF_W], SURF_DIM);
            sh = fit(reg_file[atcmp_pkg::CFG_SURF_H], SURF_DIM);
            tw = fit(reg_file[atcmp_pkg::CFG_TIP_W], TIP_DIM);
            th = fit(reg_file[atcmp_pkg::CFG_TIP_H], TIP_DIM);
        endfunction

        function int tip_height_at(int c, int r);
            if (c < 0 || r < 0) return 0;
            return int'(tip_map[r][c]);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task note_item(atcmp_pkg::t_op op, int col, int row,
                       logic signed [atcmp_pkg::SAMPLE_W-1:0] smp);
            int sw, sh, tw, th, cx, cy, reach, x, y, t, carved;
            t_read_result want;
            sizes(sw, sh, tw, th);
            want.value = 0;
            want.untouched = 1'b0;
            case (op)
                atcmp_pkg::OP_TIP_WRITE: begin
                    n_tip++;
                    if (col < tw && row < th) tip_map[row][col] = smp;
                end
                atcmp_pkg::OP_CARVE: begin
                    n_carve++;
                    if (col < sw && row < sh) begin
                        // width parity picks the centre rule for both axes
                        if (tw % 2 == 0) begin
                            cx = tw / 2 - 1;
                            cy = th / 2 - 1;
                        end else begin
                            cx = tw / 2;
                            cy = th / 2;
                        end
                        reach = int'(smp) + tip_height_at(cx, cy);
                        for (int k = 0; k < tw; k++) begin
                            for (int l = 0; l < th; l++) begin
                                x = col + k - cx;
                                y = row + l - cy;
                                t = tip_map[l][k];
                                if (x >= 0 && x < sw && y >= 0 && y < sh && t != 0) begin
                                    carved = reach - t;
                                    if (carved < boundary[y*SURF_DIM + x])
                                        boundary[y*SURF_DIM + x] = carved;
                                end
                            end
                        end
                    end
                end
                atcmp_pkg::OP_READ: begin
                    n_read++;
                    if (col < sw && row < sh) begin
                        want.value = boundary[row*SURF_DIM + col];
                        want.untouched = (want.value == atcmp_pkg::SENTINEL);
                    end
                end
                default: begin
                    n_clear++;
                    wipe_boundary();
                end
            endcase
            owed_q.push_back(want);
        endtask

        task check_result(logic signed [atcmp_pkg::VALUE_W-1:0] value, logic untouched);
            t_read_result want;
            if (owed_q.size() == 0) begin
                report($sformatf("result %0d / %0b with no item owed", value, untouched));
            end else begin
                want = owed_q.pop_front();
                if (value !== want.value)
                    report($sformatf("read_value %0d, predicted %0d", value, want.value));
                if (untouched !== want.untouched)
                    report($sformatf("untouched %0b, predicted %0b", untouched, want.untouched));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [31:0]          s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tready = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_index = '0;
    logic [8:0]           i_cfg_data = '0;
    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire  [39:0]          m_axis_tdata;

    carve_scoreboard sb;
    int  cycles = 0;
    int  taken = 0;
    int  hold = 0;
    bit  calm = 1'b0;
    int  clears_left = 4;

    int phase_cfg [PHASES][4] = '{
        '{16, 16, 4, 4},
        '{1, 1, 1, 1},
        '{0, 0, 0, 0},
        '{256, 256, 32, 1},
        '{511, 300, 1, 63},
        '{5, 7, 2, 1},
        '{9, 6, 5, 2},
        '{12, 3, 6, 3},
        '{20, 20, 9'h1c3, 9'h105},
        '{2, 256, 7, 7}
    };

    afm_tip_carve_min_plus dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result is checked before the new item is noted: a result never belongs to a same-edge input
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[31:0], m_axis_tdata[32]);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(atcmp_pkg::t_op'(s_axis_tuser), int'(s_axis_tdata[7:0]),
                             int'(s_axis_tdata[15:8]), s_axis_tdata[31:16]);
                taken++;
            end
        end
    end

    // receiver stalls in short bursts
    always @(negedge i_clk) begin
        if (!calm && hold == 0 && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 5);
        if (hold > 0) begin
            m_axis_tready <= 1'b0;
            hold--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(atcmp_pkg::t_op op, logic [7:0] col, logic [7:0] row,
                             logic [15:0] smp);
        int gap;
        int mark;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {smp, row, col};
        mark = taken;
        do @(negedge i_clk); while (taken == mark);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.owed_q.size() != 0);
    endtask

    task automatic write_reg(atcmp_pkg::t_cfg_idx idx, logic [8:0] val);
        sb.set_reg(idx, val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] tip_value();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, 400) - 200);
        endcase
    endfunction

    // mostly near the origin so carves and reads meet; edges and strays now and then
    function automatic logic [7:0] pick_coord(int limit);
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'(limit - 1);
            2:       return (limit > 255) ? 8'd255 : 8'(limit);
            default: return 8'($urandom_range(0, ((limit < 12) ? limit : 12) - 1));
        endcase
    endfunction

    task automatic run_phase(int p);
        int sw, sh, tw, th, k;
        logic [15:0] smp;
        drain();
        write_reg(atcmp_pkg::CFG_SURF_W, 9'(phase_cfg[p][0]));
        write_reg(atcmp_pkg::CFG_SURF_H, 9'(phase_cfg[p][1]));
        write_reg(atcmp_pkg::CFG_TIP_W, 9'(phase_cfg[p][2]));
        write_reg(atcmp_pkg::CFG_TIP_H, 9'(phase_cfg[p][3]));
        sb.sizes(sw, sh, tw, th);
        // every tip entry a carve can touch gets written first
        for (int r = 0; r < th; r++)
            for (int c = 0; c < tw; c++)
                send_item(atcmp_pkg::OP_TIP_WRITE, 8'(c), 8'(r), tip_value());
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            k = $urandom_range(0, 99);
            smp = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 2000) - 1000);
            if (k < 2 && clears_left > 0) begin
                clears_left--;
                send_item(atcmp_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom));
            end else if (k < 45) begin
                send_item(atcmp_pkg::OP_CARVE, pick_coord(sw), pick_coord(sh), smp);
            end else if (k < 85) begin
                send_item(atcmp_pkg::OP_READ, pick_coord(sw), pick_coord(sh), 16'($urandom));
            end else begin
                send_item(atcmp_pkg::OP_TIP_WRITE, pick_coord(tw), pick_coord(th), tip_value());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: 8x8 surface with a 3x3 tip
        write_reg(atcmp_pkg::CFG_SURF_W, 9'd8);
        write_reg(atcmp_pkg::CFG_SURF_H, 9'd8);
        write_reg(atcmp_pkg::CFG_TIP_W, 9'd3);
        write_reg(atcmp_pkg::CFG_TIP_H, 9'd3);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd0, 8'd0, 16'd0);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd1, 8'd0, 16'd5);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd2, 8'd0, 16'h8000);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd0, 8'd1, 16'd7);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd1, 8'd1, 16'd100);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd2, 8'd1, 16'h7fff);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd0, 8'd2, 16'hffff);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd1, 8'd2, 16'd2);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd2, 8'd2, 16'd3);
        send_item(atcmp_pkg::OP_CARVE, 8'd0, 8'd0, 16'h7fff);
        send_item(atcmp_pkg::OP_CARVE, 8'd7, 8'd7, 16'h8000);
        send_item(atcmp_pkg::OP_CARVE, 8'd3, 8'd4, 16'd0);
        // carves off the surface and tip writes off the tip are dropped
        send_item(atcmp_pkg::OP_CARVE, 8'd8, 8'd2, 16'd5);
        send_item(atcmp_pkg::OP_CARVE, 8'd0, 8'd255, 16'd5);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd5, 8'd1, 16'd9);
        send_item(atcmp_pkg::OP_TIP_WRITE, 8'd255, 8'd255, 16'hffff);
        send_item(atcmp_pkg::OP_READ, 8'd0, 8'd0, 16'd0);
        send_item(atcmp_pkg::OP_READ, 8'd1, 8'd1, 16'd0);
        send_item(atcmp_pkg::OP_READ, 8'd7, 8'd7, 16'd0);
        send_item(atcmp_pkg::OP_READ, 8'd3, 8'd3, 16'd0);
        send_item(atcmp_pkg::OP_READ, 8'd6, 8'd0, 16'd0);
        send_item(atcmp_pkg::OP_READ, 8'd255, 8'd255, 16'hffff);
        send_item(atcmp_pkg::OP_READ, 8'd8, 8'd0, 16'd0);
        send_item(atcmp_pkg::OP_CLEAR, 8'd0, 8'd0, 16'd0);
        send_item(atcmp_pkg::OP_READ, 8'd3, 8'd4, 16'd0);

        // random phases; the sender waits for all results before each register update
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) calm = 1'b1;
            run_phase(p);
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("covered %0d tip writes, %0d carves, %0d reads, %0d clears",
                 sb.n_tip, sb.n_carve, sb.n_read, sb.n_clear);
        $display("over %0d register writes in %0d cycles", sb.n_cfg, cycles);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/atcmp_pkg.sv
sv/afm_tip_carve_min_plus.sv
sv/atcmp_chk.sv
dv/tb.sv
